// ===== rtl/mau_pkg.sv =====
// Shared types, constants and helper functions for the Metropolis acceptance unit.
// No dependencies; every other file in rtl/ imports this package.
package mau_pkg;

  localparam int COUNT_WIDTH_DEF    = 48;
  localparam int PATH_FRAC_BITS_DEF = 24;

  localparam logic [23:0] LN2_Q24    = 24'd11629080;
  localparam logic [24:0] LN2_RECIP  = 25'((64'd1 << 48) / 64'(LN2_Q24));
  localparam logic [7:0]  EXP_CUTOFF = 8'd22;
  localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
  localparam logic [3:0]  HORNER_TERMS = 4'd12;

  localparam logic [6:0] DIV_STEPS_GROUPS = 7'd64;
  localparam logic [6:0] DIV_STEPS_EXPON  = 7'd30;
  localparam logic [6:0] DIV_STEPS_RECIP  = 7'd33;

  localparam int          PADDR_W = 6;
  localparam int          PDATA_W = 64;
  localparam logic [15:0] NODE_COUNT_RST = 16'd256;
  localparam logic [2:0]  SYM_GROUPS_RST = 3'd1;
  localparam logic [31:0] FIXED_TEMP_RST = 32'd65536;

  typedef enum logic [2:0] {
    REG_NODE_COUNT,
    REG_SYM_GROUPS,
    REG_HILL_CLIMB,
    REG_DETECT_TEMP,
    REG_USE_FIXED,
    REG_FIXED_TEMP,
    REG_SKIP_THRESH
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIV_GROUPS,
    DIV_EXPON,
    DIV_RECIP
  } div_sel_e;

  typedef struct packed {
    logic [31:0] new_path_length;
    logic [31:0] cur_path_length;
    logic [9:0]  new_diameter;
    logic [9:0]  cur_diameter;
    logic [31:0] temperature;
    logic [47:0] iteration;
    logic [30:0] random_word;
    logic        clear_window;
  } mau_in_t;

  typedef struct packed {
    logic               accepted;
    logic [47:0]        accept_total;
    logic [47:0]        reject_total;
    logic [47:0]        late_accept_total;
    logic signed [63:0] max_energy_rise;
  } mau_out_t;

  typedef struct packed {
    logic [15:0] node_count;
    logic [2:0]  symmetry_groups;
    logic        hill_climb_mode;
    logic        detect_temp_mode;
    logic        use_fixed_temp;
    logic [31:0] fixed_temperature;
    logic [47:0] skip_threshold;
  } mau_cfg_t;

  typedef struct packed {
    logic     load;
    logic     mul_m;
    logic     mul_d;
    logic     div_start;
    div_sel_e div_sel;
    logic     gain;
    logic     red_mul;
    logic     red_fix;
    logic     hor_mul;
    logic     hor_rcp;
    logic     hor_fix;
    logic [3:0] hor_n;
    logic     commit;
    logic     accept;
  } mau_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic detect;
    logic hill;
    logic diam_lt;
    logic diam_gt;
    logic nonneg;
    logic over_cut;
    logic exp_pass;
    logic out_free;
  } mau_sts_t;

  // floor(2^32 / n), all ones for n = 1; estimate is low by at most one
  function automatic logic [31:0] horner_recip(input logic [3:0] n);
    logic [31:0] r;
    case (n)
      4'd1:    r = 32'hFFFF_FFFF;
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      4'd11:   r = 32'h1745_D174;
      4'd12:   r = 32'h1555_5555;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/mau_if.sv =====
// Valid/ready stream interfaces for proposal beats and result beats.
// Depends on mau_pkg for the payload structs.
interface mau_in_if import mau_pkg::*; ();
  logic    valid;
  logic    ready;
  mau_in_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mau_out_if import mau_pkg::*; ();
  logic     valid;
  logic     ready;
  mau_out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/metropolis_accept_unit.sv =====
// Top level of the Metropolis acceptance unit: config registers, controller, datapath.
// Depends on mau_pkg, mau_if, mau_ctrl, mau_dp.
//
// Usage:
//  - in_i carries one annealing proposal per beat (valid/ready). out_o returns
//    exactly one result beat per proposal, in order: decision, window accept and
//    reject counts, late accept count and largest energy rise.
//  - The APB port writes/reads the seven config registers at 8*index. The
//    registers feed the datapath directly, so write them only while idle.
//  - A result takes longer when the exponential test runs than when the
//    diameter or sign rules decide. The shared radix-2 divider runs 64 steps
//    for the group division, 30 for rise/T and 33 for the 2^62/t reciprocal;
//    the Horner series takes 36 steps.
//  - One proposal is in flight at a time; in_i.ready is high while idle, so
//    a new beat is taken only after the previous one has committed its result.
//  - Result sits in an output register; a stalled receiver does not block the
//    next proposal, which runs to its final step and waits there until the
//    register frees up, then commits its counters.
//  - Reset: counters and largest rise clear to zero, registers take defaults
//    (N=256, one group, fixed temperature 1.0), no result pending.
module metropolis_accept_unit import mau_pkg::*; #(
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
  parameter int PATH_FRAC_BITS = PATH_FRAC_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  mau_in_if.sink             in_i,
  mau_out_if.source          out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  mau_cfg_t cfg_q;
  mau_cmd_t cmd;
  mau_sts_t sts;
  logic     wr_en;
  reg_idx_e idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[5:3]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.node_count        <= NODE_COUNT_RST;
      cfg_q.symmetry_groups   <= SYM_GROUPS_RST;
      cfg_q.hill_climb_mode   <= 1'b0;
      cfg_q.detect_temp_mode  <= 1'b0;
      cfg_q.use_fixed_temp    <= 1'b0;
      cfg_q.fixed_temperature <= FIXED_TEMP_RST;
      cfg_q.skip_threshold    <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_NODE_COUNT:  cfg_q.node_count        <= pwdata[15:0];
        REG_SYM_GROUPS:  cfg_q.symmetry_groups   <= pwdata[2:0];
        REG_HILL_CLIMB:  cfg_q.hill_climb_mode   <= pwdata[0];
        REG_DETECT_TEMP: cfg_q.detect_temp_mode  <= pwdata[0];
        REG_USE_FIXED:   cfg_q.use_fixed_temp    <= pwdata[0];
        REG_FIXED_TEMP:  cfg_q.fixed_temperature <= pwdata[31:0];
        REG_SKIP_THRESH: cfg_q.skip_threshold    <= pwdata[47:0];
        default: ;  // unmapped slot, write dropped
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NODE_COUNT:  prdata = 64'(cfg_q.node_count);
      REG_SYM_GROUPS:  prdata = 64'(cfg_q.symmetry_groups);
      REG_HILL_CLIMB:  prdata = 64'(cfg_q.hill_climb_mode);
      REG_DETECT_TEMP: prdata = 64'(cfg_q.detect_temp_mode);
      REG_USE_FIXED:   prdata = 64'(cfg_q.use_fixed_temp);
      REG_FIXED_TEMP:  prdata = 64'(cfg_q.fixed_temperature);
      REG_SKIP_THRESH: prdata = 64'(cfg_q.skip_threshold);
      default:         prdata = '0;
    endcase
  end

  mau_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  mau_dp #(
    .COUNT_WIDTH   (COUNT_WIDTH),
    .PATH_FRAC_BITS(PATH_FRAC_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .in_payload_i (in_i.payload),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_payload_o(out_o.payload)
  );

endmodule

// ===== rtl/mau_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on mau_pkg (imported for house consistency).
module mau_div import mau_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] rem_i,
  input  logic [63:0] dvd_i,
  input  logic [31:0] divisor_i,
  input  logic [6:0]  steps_i,
  output logic        busy_o,
  output logic [63:0] quot_o
);

  logic        busy_q;
  logic [6:0]  cnt_q;
  logic [31:0] rem_q, dsr_q;
  logic [63:0] dvd_q, quot_q;
  logic [32:0] trial, diff;
  logic        ge;

  assign trial = {rem_q, dvd_q[63]};
  assign diff  = trial - {1'b0, dsr_q};
  assign ge    = trial >= {1'b0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= steps_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 7'd1;
      if (cnt_q == 7'd1) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= rem_i;
      dvd_q  <= dvd_i;
      dsr_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[31:0] : trial[31:0];
      dvd_q  <= {dvd_q[62:0], 1'b0};
      quot_q <= {quot_q[62:0], ge};
    end
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;

endmodule

// ===== rtl/mau_dp.sv =====
// Datapath: energy gain, exp(-rise/T) evaluation, counters and result register.
// Depends on mau_pkg and mau_div.
module mau_dp import mau_pkg::*; #(
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
  parameter int PATH_FRAC_BITS = PATH_FRAC_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mau_cfg_t cfg_i,
  input  mau_in_t  in_payload_i,
  input  mau_cmd_t cmd_i,
  output mau_sts_t sts_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output mau_out_t out_payload_o
);

  localparam int XSH = 40 - PATH_FRAC_BITS;
  localparam int SL  = (PATH_FRAC_BITS >= 16) ? PATH_FRAC_BITS - 16 : 0;
  localparam int SR  = (PATH_FRAC_BITS < 16) ? 16 - PATH_FRAC_BITS : 0;

  // item registers
  logic        neg_q, lt_q, gt_q, clr_q, nonneg_q;
  logic [31:0] d_q, temp_q, m_q;
  logic [47:0] iter_q;
  logic [30:0] r_q;
  logic [63:0] prod_q;
  logic [62:0] rise_q;
  logic [29:0] x_q, g30_q;
  logic [54:0] red_prod_q;
  logic [5:0]  k_q;
  logic [31:0] t_q, p_q;
  logic [61:0] hp_q;
  logic [63:0] hq_q;

  // persistent state
  logic [COUNT_WIDTH-1:0] wa_q, wr_q, la_q;
  logic signed [63:0]     largest_q;
  logic                   out_valid_q;
  mau_out_t               out_q;

  logic [31:0] temp_sel, temp_ld;
  logic [2:0]  grp;

  assign temp_sel = cfg_i.use_fixed_temp ? cfg_i.fixed_temperature
                                         : in_payload_i.temperature;
  assign temp_ld  = (temp_sel == 32'd0) ? 32'd1 : temp_sel;
  assign grp      = (cfg_i.symmetry_groups == 3'd0) ? 3'd1 : cfg_i.symmetry_groups;

  // divider operand select
  logic        div_busy;
  logic [63:0] div_quot;
  logic [31:0] div_rem, div_dsr;
  logic [63:0] div_dvd;
  logic [6:0]  div_steps;
  logic [95:0] x_dvd_w;
  logic [63:0] x_dvd;

  assign x_dvd_w = 96'(rise_q) << XSH;
  assign x_dvd   = x_dvd_w[63:0];

  always_comb begin
    case (cmd_i.div_sel)
      DIV_EXPON: begin
        div_rem   = x_dvd[61:30];
        div_dvd   = {x_dvd[29:0], 34'd0};
        div_dsr   = temp_q;
        div_steps = DIV_STEPS_EXPON;
      end
      DIV_RECIP: begin
        div_rem   = 32'd1 << 29;
        div_dvd   = '0;
        div_dsr   = t_q;
        div_steps = DIV_STEPS_RECIP;
      end
      default: begin
        div_rem   = '0;
        div_dvd   = prod_q;
        div_dsr   = {29'd0, grp};
        div_steps = DIV_STEPS_GROUPS;
      end
    endcase
  end

  mau_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.div_start),
    .rem_i    (div_rem),
    .dvd_i    (div_dvd),
    .divisor_i(div_dsr),
    .steps_i  (div_steps),
    .busy_o   (div_busy),
    .quot_o   (div_quot)
  );

  // gain: clamp the magnitude, sign applied for the largest-rise tracker
  logic [62:0]        mag_c;
  logic signed [63:0] cand;

  assign mag_c = div_quot[63] ? '1 : div_quot[62:0];
  assign cand  = neg_q ? $signed({1'b0, mag_c}) : -$signed({1'b0, mag_c});

  // cutoff: rise >= 22*T scaled to the path format
  logic [71:0] lim_lhs, lim_rhs;
  assign lim_lhs = 72'(rise_q) << SR;
  assign lim_rhs = (72'(temp_q) * 72'(EXP_CUTOFF)) << SL;

  // range reduction, k estimate may be one low
  logic [6:0]  k0;
  logic [30:0] kl, r0, r_fin;
  logic        r_fix;

  assign k0    = red_prod_q[54:48];
  assign kl    = 31'(k0) * 31'(LN2_Q24);
  assign r0    = 31'(x_q) - kl;
  assign r_fix = r0 >= 31'(LN2_Q24);
  assign r_fin = r_fix ? r0 - 31'(LN2_Q24) : r0;

  // Horner division by n through reciprocal, one correction step
  logic [31:0] qe, q_fin;
  logic [35:0] hrem;
  logic        h_fix;

  assign qe    = hq_q[63:32];
  assign hrem  = 36'(p_q) - 36'(qe) * 36'(cmd_i.hor_n);
  assign h_fix = hrem >= 36'(cmd_i.hor_n);
  assign q_fin = qe + 32'(h_fix);

  // final compare E*(2^31+1) > (r+1)*2^32
  logic [32:0] e_sh;
  logic [64:0] e_lhs, e_rhs;
  logic [31:0] r_inc;

  assign e_sh  = div_quot[32:0] >> k_q;
  assign e_lhs = 65'({e_sh, 31'd0}) + 65'(e_sh);
  assign r_inc = 32'(r_q) + 32'd1;
  assign e_rhs = 65'({r_inc, 32'd0});

  // commit
  logic [COUNT_WIDTH-1:0] wa_base, wr_base, wa_new, wr_new, la_new;
  logic [63:0]            wa_ext, wr_ext, la_ext;
  logic                   late_hit;

  always_comb begin
    wa_base  = clr_q ? '0 : wa_q;
    wr_base  = clr_q ? '0 : wr_q;
    late_hit = iter_q > cfg_i.skip_threshold;
    wa_new   = wa_base;
    wr_new   = wr_base;
    la_new   = la_q;
    if (cmd_i.accept) begin
      wa_new = (wa_base == '1) ? wa_base : wa_base + 1'b1;
      if (late_hit) la_new = (la_q == '1) ? la_q : la_q + 1'b1;
    end else begin
      wr_new = (wr_base == '1) ? wr_base : wr_base + 1'b1;
    end
    wa_ext = 64'(wa_new);
    wr_ext = 64'(wr_new);
    la_ext = 64'(la_new);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      neg_q  <= in_payload_i.new_path_length > in_payload_i.cur_path_length;
      d_q    <= (in_payload_i.new_path_length > in_payload_i.cur_path_length)
              ? in_payload_i.new_path_length - in_payload_i.cur_path_length
              : in_payload_i.cur_path_length - in_payload_i.new_path_length;
      lt_q   <= in_payload_i.new_diameter < in_payload_i.cur_diameter;
      gt_q   <= in_payload_i.new_diameter > in_payload_i.cur_diameter;
      temp_q <= temp_ld;
      iter_q <= in_payload_i.iteration;
      r_q    <= in_payload_i.random_word;
      clr_q  <= in_payload_i.clear_window;
    end
    if (cmd_i.mul_m) begin
      m_q <= (cfg_i.node_count >= 16'd2)
           ? 32'(cfg_i.node_count) * 32'(cfg_i.node_count - 16'd1) : 32'd0;
    end
    if (cmd_i.mul_d) prod_q <= 64'(d_q) * 64'(m_q);
    if (cmd_i.gain) begin
      rise_q   <= mag_c;
      nonneg_q <= !neg_q || (div_quot == 64'd0);
    end
    if (cmd_i.red_mul) begin
      x_q        <= div_quot[29:0];
      red_prod_q <= 55'(div_quot[29:0]) * 55'(LN2_RECIP);
    end
    if (cmd_i.red_fix) begin
      k_q   <= 6'(k0) + 6'(r_fix);
      g30_q <= {r_fin[23:0], 6'd0};
      t_q   <= ONE_Q30;
    end
    if (cmd_i.hor_mul) hp_q <= 62'(g30_q) * 62'(t_q);
    if (cmd_i.hor_rcp) begin
      p_q  <= hp_q[61:30];
      hq_q <= 64'(hp_q[61:30]) * 64'(horner_recip(cmd_i.hor_n));
    end
    if (cmd_i.hor_fix) t_q <= ONE_Q30 + q_fin;
    if (cmd_i.commit) begin
      out_q.accepted          <= cmd_i.accept;
      out_q.accept_total      <= wa_ext[47:0];
      out_q.reject_total      <= wr_ext[47:0];
      out_q.late_accept_total <= la_ext[47:0];
      out_q.max_energy_rise   <= largest_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wa_q        <= '0;
      wr_q        <= '0;
      la_q        <= '0;
      largest_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.gain && cfg_i.detect_temp_mode && (cand > largest_q)) largest_q <= cand;
      if (cmd_i.commit) begin
        wa_q        <= wa_new;
        wr_q        <= wr_new;
        la_q        <= la_new;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign sts_o.div_busy = div_busy;
  assign sts_o.detect   = cfg_i.detect_temp_mode;
  assign sts_o.hill     = cfg_i.hill_climb_mode;
  assign sts_o.diam_lt  = lt_q;
  assign sts_o.diam_gt  = gt_q;
  assign sts_o.nonneg   = nonneg_q;
  assign sts_o.over_cut = lim_lhs >= lim_rhs;
  assign sts_o.exp_pass = e_lhs > e_rhs;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign out_payload_o = out_q;

endmodule

// ===== rtl/mau_ctrl.sv =====
// Controller: sequences one proposal through the datapath and picks the decision.
// Depends on mau_pkg for the command and status structs.
module mau_ctrl import mau_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  mau_sts_t sts_i,
  output mau_cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE, S_MUL_M, S_MUL_D, S_DIVG_GO, S_DIVG, S_GAIN, S_DECIDE,
    S_DIVX_GO, S_DIVX, S_RED_MUL, S_RED_FIX, S_HOR_MUL, S_HOR_RCP, S_HOR_FIX,
    S_DIVE_GO, S_DIVE, S_EXP_DEC, S_COMMIT
  } state_e;

  state_e     state_q, state_d;
  logic [3:0] n_q, n_d;
  logic       acc_q, acc_d;

  always_comb begin
    logic go_exp;
    go_exp  = 1'b0;
    state_d = state_q;
    n_d     = n_q;
    acc_d   = acc_q;
    unique case (state_q)
      S_IDLE:    if (in_valid_i) state_d = S_MUL_M;
      S_MUL_M:   state_d = S_MUL_D;
      S_MUL_D:   state_d = S_DIVG_GO;
      S_DIVG_GO: state_d = S_DIVG;
      S_DIVG:    if (!sts_i.div_busy) state_d = S_GAIN;
      S_GAIN:    state_d = S_DECIDE;
      S_DECIDE: begin
        state_d = S_COMMIT;
        if (sts_i.detect) begin
          if (sts_i.nonneg) acc_d = 1'b1;
          else go_exp = 1'b1;
        end else if (sts_i.diam_lt) begin
          acc_d = 1'b1;
        end else if (sts_i.diam_gt) begin
          acc_d = 1'b0;
        end else if (sts_i.nonneg) begin
          acc_d = 1'b1;
        end else if (sts_i.hill) begin
          acc_d = 1'b0;
        end else begin
          go_exp = 1'b1;
        end
        if (go_exp) begin
          acc_d = 1'b0;
          if (!sts_i.over_cut) state_d = S_DIVX_GO;
        end
      end
      S_DIVX_GO: state_d = S_DIVX;
      S_DIVX:    if (!sts_i.div_busy) state_d = S_RED_MUL;
      S_RED_MUL: state_d = S_RED_FIX;
      S_RED_FIX: begin
        n_d     = HORNER_TERMS;
        state_d = S_HOR_MUL;
      end
      S_HOR_MUL: state_d = S_HOR_RCP;
      S_HOR_RCP: state_d = S_HOR_FIX;
      S_HOR_FIX: begin
        n_d     = n_q - 4'd1;
        state_d = (n_q == 4'd1) ? S_DIVE_GO : S_HOR_MUL;
      end
      S_DIVE_GO: state_d = S_DIVE;
      S_DIVE:    if (!sts_i.div_busy) state_d = S_EXP_DEC;
      S_EXP_DEC: begin
        acc_d   = sts_i.exp_pass;
        state_d = S_COMMIT;
      end
      S_COMMIT:  if (sts_i.out_free) state_d = S_IDLE;
      default:   state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      n_q     <= '0;
      acc_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      n_q     <= n_d;
      acc_q   <= acc_d;
    end
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.load      = (state_q == S_IDLE) && in_valid_i;
    cmd_o.mul_m     = state_q == S_MUL_M;
    cmd_o.mul_d     = state_q == S_MUL_D;
    cmd_o.div_start = (state_q == S_DIVG_GO) || (state_q == S_DIVX_GO) ||
                      (state_q == S_DIVE_GO);
    cmd_o.div_sel   = (state_q == S_DIVX_GO) ? DIV_EXPON :
                      (state_q == S_DIVE_GO) ? DIV_RECIP : DIV_GROUPS;
    cmd_o.gain      = state_q == S_GAIN;
    cmd_o.red_mul   = state_q == S_RED_MUL;
    cmd_o.red_fix   = state_q == S_RED_FIX;
    cmd_o.hor_mul   = state_q == S_HOR_MUL;
    cmd_o.hor_rcp   = state_q == S_HOR_RCP;
    cmd_o.hor_fix   = state_q == S_HOR_FIX;
    cmd_o.hor_n     = n_q;
    cmd_o.commit    = (state_q == S_COMMIT) && sts_i.out_free;
    cmd_o.accept    = acc_q;
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule

// ===== rtl/mau_checker.sv =====
// Port-level assertions for metropolis_accept_unit, attached by bind.
// Depends on mau_pkg for the result struct.
module mau_checker import mau_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input mau_out_t out_payload_i
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_payload_i))
    else $error("result beat changed under stall");

  // one proposal in flight: busy right after an accept
  a_busy_after_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second proposal taken while busy");

  // largest rise starts at zero and only grows
  a_rise_nonneg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> !out_payload_i.max_energy_rise[63])
    else $error("negative largest energy rise");

  a_acc_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_payload_i.accepted |-> out_payload_i.accept_total != 48'd0)
    else $error("accept without accept count");

  a_rej_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_payload_i.accepted |-> out_payload_i.reject_total != 48'd0)
    else $error("reject without reject count");

endmodule

bind metropolis_accept_unit mau_checker u_mau_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_payload_i(out_o.payload)
);
